>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker modules of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/rfa_pkg.sv
// ----------------------------------------------------------------------------
// Ring fork arbiter package
// Request and result types, action codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int CLIENT_W    = 3;
  localparam int ACTION_W    = 3;
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = 3;

  localparam logic [ACTION_W-1:0] ACT_HUNGRY = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DONE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TOGGLE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PAUSE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RESUME = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CLIENT_W-1:0] client;
  } in_item_t;

  typedef struct packed {
    logic [CLIENT_W-1:0] granted_client;
    logic                last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HUNGRY,
    ST_FREE,
    ST_TRY_R,
    ST_TRY_L,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_HUNGRY,
    DP_FREE,
    DP_TRY_R,
    DP_TRY_L,
    DP_SCAN,
    DP_FLUSH
  } dp_op_t;

  typedef struct packed {
    logic   load;
    logic   set_pause;
    logic   clr_pause;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic paused;
    logic client_ok;
    logic scan_last;
  } dp_status_t;

endpackage

>>> rtl/core/ring_fork_arbiter.sv
// Busy after an accepted request: hungry for a valid client, even one already waiting,
// runs ST_HUNGRY, ST_FLUSH; done ST_FREE, ST_TRY_R, ST_TRY_L, ST_FLUSH (ST_FREE, ST_FLUSH
// if paused); a scan on leaving pause ST_SCAN per client, ST_FLUSH; others take none.
// The controller walks grant attempts one per cycle; the scan visits one client a cycle.
// A hungry grant shows on result as busy drops, so a request in that cycle is taken.
// Synchronous reset frees all resources, clears waiting and leaves the pause state.
// ----------------------------------------------------------------------------
// Ring fork arbiter
// Grants clients in a ring both neighboring resources at once, queues
// waiting clients and serves them on release or on leaving pause.
// ----------------------------------------------------------------------------
module ring_fork_arbiter #(
  parameter int CLIENTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rfa_pkg::in_item_t  item,
  output logic               strobe,
  output rfa_pkg::out_item_t result
);
  import rfa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rfa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rfa_datapath #(
    .CLIENTS (CLIENTS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .strobe (strobe),
    .result (result)
  );

endmodule

>>> rtl/core/rfa_datapath.sv
// ----------------------------------------------------------------------------
// Ring fork arbiter datapath
// Resource and waiting flags, pause flag, grant test and the result register
// with a one-deep pending stage that lets the final grant carry its last mark.
// ----------------------------------------------------------------------------
module rfa_datapath #(
  parameter int CLIENTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  rfa_pkg::in_item_t   item,
  input  rfa_pkg::dp_cmd_t    cmd,
  output rfa_pkg::dp_status_t status,
  output logic                strobe,
  output rfa_pkg::out_item_t  result
);
  import rfa_pkg::*;

  localparam int IW = $clog2(CLIENTS);

  logic [CLIENTS-1:0] res_busy;
  logic [CLIENTS-1:0] waiting;
  logic               paused;
  logic [IW-1:0]      cur;
  logic [IW-1:0]      scan_idx;
  logic [CNT_W-1:0]   grant_cnt;
  logic               pend_valid;
  logic [IW-1:0]      pend_idx;

  logic [IW-1:0]      tgt;
  logic [IW-1:0]      tgt_nx;
  logic [IW-1:0]      cur_nx;
  logic               both_free;
  logic               room;
  logic               do_grant;
  logic               do_wait;

  function automatic logic [IW-1:0] next_of(input logic [IW-1:0] i);
    return (i == IW'(CLIENTS - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] prev_of(input logic [IW-1:0] i);
    return (i == '0) ? IW'(CLIENTS - 1) : i - 1'b1;
  endfunction

  always_comb begin
    unique case (cmd.op)
      DP_TRY_R: tgt = prev_of(cur);
      DP_TRY_L: tgt = next_of(cur);
      DP_SCAN:  tgt = scan_idx;
      default:  tgt = cur;
    endcase
  end

  assign tgt_nx    = next_of(tgt);
  assign cur_nx    = next_of(cur);
  assign both_free = !res_busy[tgt] && !res_busy[tgt_nx];
  assign room      = grant_cnt < CNT_W'(MAX_RESULTS);

  always_comb begin
    unique case (cmd.op)
      DP_HUNGRY:                  do_grant = !waiting[cur] && !paused && both_free && room;
      DP_TRY_R, DP_TRY_L, DP_SCAN: do_grant = waiting[tgt] && both_free && room;
      default:                    do_grant = 1'b0;
    endcase
  end

  // A hungry client that cannot be served right away is queued as waiting.
  assign do_wait = (cmd.op == DP_HUNGRY) && !waiting[cur] && !do_grant;

  assign status.paused    = paused;
  assign status.client_ok = 32'(item.client) < CLIENTS;
  assign status.scan_last = scan_idx == IW'(CLIENTS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_busy   <= '0;
      waiting    <= '0;
      paused     <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.set_pause) begin
        paused <= 1'b1;
      end
      if (cmd.clr_pause) begin
        paused <= 1'b0;
      end
      if (cmd.load) begin
        cur        <= IW'(item.client);
        scan_idx   <= '0;
        grant_cnt  <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.op == DP_FREE) begin
        res_busy[cur]    <= 1'b0;
        res_busy[cur_nx] <= 1'b0;
      end
      if (cmd.op == DP_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (do_wait) begin
        waiting[cur] <= 1'b1;
      end
      // A new grant pushes the previous one out; it cannot be the last.
      if (do_grant) begin
        res_busy[tgt]    <= 1'b1;
        res_busy[tgt_nx] <= 1'b1;
        waiting[tgt]     <= 1'b0;
        grant_cnt        <= grant_cnt + 1'b1;
        pend_idx         <= tgt;
        pend_valid       <= 1'b1;
        if (pend_valid) begin
          strobe                <= 1'b1;
          result.granted_client <= CLIENT_W'(pend_idx);
          result.last           <= 1'b0;
        end
      end
      if (cmd.op == DP_FLUSH) begin
        strobe                <= pend_valid;
        result.granted_client <= CLIENT_W'(pend_idx);
        result.last           <= 1'b1;
        pend_valid            <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/rfa_ctrl.sv
// ----------------------------------------------------------------------------
// Ring fork arbiter controller
// Decodes each accepted request and steps the datapath through the grant
// attempts it calls for, ending each one that leaves idle with a result flush.
// ----------------------------------------------------------------------------
module rfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rfa_pkg::in_item_t   item,
  input  rfa_pkg::dp_status_t status,
  output rfa_pkg::dp_cmd_t    cmd,
  output logic                busy
);
  import rfa_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);
  assign busy   = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.action)
            ACT_HUNGRY:             state_next = status.client_ok ? ST_HUNGRY : ST_IDLE;
            ACT_DONE:               state_next = status.client_ok ? ST_FREE : ST_IDLE;
            ACT_TOGGLE, ACT_RESUME: state_next = status.paused ? ST_SCAN : ST_IDLE;
            default:                state_next = ST_IDLE;
          endcase
        end
      end
      ST_HUNGRY: state_next = ST_FLUSH;
      ST_FREE:   state_next = status.paused ? ST_FLUSH : ST_TRY_R;
      ST_TRY_R:  state_next = ST_TRY_L;
      ST_TRY_L:  state_next = ST_FLUSH;
      ST_SCAN:   state_next = status.scan_last ? ST_FLUSH : ST_SCAN;
      ST_FLUSH:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{load: 1'b0, set_pause: 1'b0, clr_pause: 1'b0, op: DP_NONE};
    unique case (state)
      ST_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          unique case (item.action)
            ACT_TOGGLE: begin
              cmd.set_pause = !status.paused;
              cmd.clr_pause = status.paused;
            end
            ACT_PAUSE:  cmd.set_pause = 1'b1;
            ACT_RESUME: cmd.clr_pause = status.paused;
            default:    cmd.op = DP_NONE;
          endcase
        end
      end
      ST_HUNGRY: cmd.op = DP_HUNGRY;
      ST_FREE:   cmd.op = DP_FREE;
      ST_TRY_R:  cmd.op = DP_TRY_R;
      ST_TRY_L:  cmd.op = DP_TRY_L;
      ST_SCAN:   cmd.op = DP_SCAN;
      ST_FLUSH:  cmd.op = DP_FLUSH;
      default:   cmd.op = DP_NONE;
    endcase
  end

endmodule

>>> rtl/core/rfa_checker.sv
// ----------------------------------------------------------------------------
// Ring fork arbiter checker
// Port-level checks on result timing against the busy indication.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfa_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input rfa_pkg::in_item_t  item,
  input logic               strobe,
  input rfa_pkg::out_item_t result
);
  import rfa_pkg::*;

  logic pause_req;
  assign pause_req = start && !busy && (item.action == ACT_PAUSE);

  // Reset leaves the block idle with no result showing.
  `ASSERT_NXT(a_reset_quiet, clk, 1'b0, rst, !busy && !strobe, "result or busy after reset")

  // A grant that is not the last of its request means more work is pending.
  `ASSERT_IMP(a_more_pending, clk, rst, strobe && !result.last, busy, "non-final result while idle")

  // No result can appear in the cycle after an idle cycle.
  `ASSERT_NXT(a_idle_no_result, clk, rst, !busy, !strobe, "result without a request in flight")

  // The final result of a request is never followed directly by another result.
  `ASSERT_NXT(a_last_gap, clk, rst, strobe && result.last, !strobe, "result right after final one")

  // A pause request only sets the pause flag and leaves the block idle.
  `ASSERT_NXT(a_pause_idle, clk, rst, pause_req, !busy, "busy after a pause request")

endmodule

bind ring_fork_arbiter rfa_checker u_rfa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .strobe (strobe),
  .result (result)
);
